// ----- rtl/core/dasd_pkg.sv -----
package dasd_pkg;

   // Parser phases
   localparam int PHASE_W = 5;
   localparam logic [PHASE_W-1:0] PH_HDR   = 5'd0;
   localparam logic [PHASE_W-1:0] PH_STUFF = 5'd1;
   localparam logic [PHASE_W-1:0] PH_PKT   = 5'd2;
   localparam logic [PHASE_W-1:0] PH_SKIP  = 5'd3;
   localparam logic [PHASE_W-1:0] PH_PAD1  = 5'd4;
   localparam logic [PHASE_W-1:0] PH_EXT1  = 5'd5;
   localparam logic [PHASE_W-1:0] PH_CODEC = 5'd6;
   localparam logic [PHASE_W-1:0] PH_PCM   = 5'd7;
   localparam logic [PHASE_W-1:0] PH_EXT2  = 5'd8;
   localparam logic [PHASE_W-1:0] PH_PAY   = 5'd9;
   localparam logic [PHASE_W-1:0] PH_SINK  = 5'd10;

   // Sector status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
   localparam logic [2:0] ST_BAD_MARK  = 3'd2;
   localparam logic [2:0] ST_BAD_START = 3'd3;
   localparam logic [2:0] ST_NO_AUDIO  = 3'd4;
   localparam logic [2:0] ST_TRUNC     = 3'd5;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // CSR indexes and reset values
   localparam logic CSR_AUDIO_ID = 1'b0;
   localparam logic CSR_PCM_ID   = 1'b1;
   localparam logic [7:0] AUDIO_ID_RST = 8'hBD;
   localparam logic [7:0] PCM_ID_RST   = 8'hA0;

   // Stream constants
   localparam logic [31:0] PACK_SYNC   = 32'h0000_01BA;
   localparam logic [23:0] PKT_PREFIX  = 24'h00_0001;
   localparam logic [7:0]  PCM_HDR_MIN = 8'd9;

   // Result data layout
   localparam int RSP_DATA_W  = 67;
   localparam int RSP_TDATA_W = 72;
   localparam int CAP_W       = 56;

   localparam int QUEUE_DEPTH_DEF = 8;

endpackage

// ----- rtl/core/dvd_audio_sector_demux_top.sv -----
// Path: input register, combinational parser, then the result queue that drives rsp_.
// Throughput: one sector byte per cycle while rsp_tready stays high; the last byte of a
// sector can yield two beats (payload and status), absorbed by the result queue.
// Stall: req_tready drops once the queue lacks room for two beats per byte in flight.
// Reset: synchronous, active high; parser rearms at the pack header, CSRs return to
// 0xBD / 0xA0 and the result queue empties. No clearing pass.
module dvd_audio_sector_demux_top
   import dasd_pkg::*;
#(
   parameter int RSP_QUEUE_DEPTH = QUEUE_DEPTH_DEF   // power of two, at least 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // sector byte stream
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [7:0]             req_tdata,    // [7:0] data_byte
   input  logic                   req_tlast,    // sector_end
   // result stream
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] payload_byte, [10:8] status, [18:11] codec, [26:19] packet_crc,
   // [42:27] frame offset, [46:43] group1_bits_code, [50:47] group2_bits_code,
   // [54:51] group1_rate_code, [58:55] group2_rate_code, [66:59] channel_layout,
   // [71:67] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [1:0]             rsp_tuser,    // [0] kind, [1] packet_first
   // configuration
   input  logic                   csr_we,
   input  logic                   csr_addr,
   input  logic [7:0]             csr_wdata
);

   localparam int PTR_W   = $clog2(RSP_QUEUE_DEPTH);
   localparam int CNT_W   = $clog2(RSP_QUEUE_DEPTH + 1);
   localparam int ENTRY_W = RSP_DATA_W + 2;

   // ---------------- configuration registers ----------------
   logic [7:0] audio_id_ff;
   logic [7:0] pcm_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         audio_id_ff <= AUDIO_ID_RST;
         pcm_id_ff   <= PCM_ID_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_AUDIO_ID: audio_id_ff <= csr_wdata;
            CSR_PCM_ID:   pcm_id_ff   <= csr_wdata;
            default:      audio_id_ff <= audio_id_ff;
         endcase
      end
   end

   // ---------------- input register ----------------
   logic       in_vld_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       req_beat;

   assign req_beat = req_tvalid & req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= req_beat;
      end
      if (req_beat) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // ---------------- parser state ----------------
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         idx_ff, idx_in;
   logic [23:0]        win_ff, win_in;      // last three bytes; the fourth is the new one
   logic [15:0]        left_ff, left_in;
   logic [7:0]         ext_ff, ext_in;
   logic [7:0]         fmt_ff, fmt_in;
   logic [2:0]         stuff_ff, stuff_in;
   logic               seen_ff, seen_in;
   logic [2:0]         err_ff, err_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;

   logic [31:0]        win;
   logic [7:0]         b;
   logic [PHASE_W-1:0] ph;
   logic [3:0]         idx;
   logic [15:0]        left;
   logic [7:0]         ext;
   logic [7:0]         fmt;
   logic [2:0]         stuff;
   logic               seen;
   logic [2:0]         err;
   logic [CAP_W-1:0]   cap;
   logic               ok;
   logic               pay_vld;
   logic               pay_first;
   logic [2:0]         status;

   assign b   = in_byte_ff;
   assign win = {win_ff, in_byte_ff};

   always_comb begin
      ph        = phase_ff;
      idx       = idx_ff;
      left      = left_ff;
      ext       = ext_ff;
      fmt       = fmt_ff;
      stuff     = stuff_ff;
      seen      = seen_ff;
      err       = err_ff;
      cap       = cap_ff;
      ok        = 1'b0;
      pay_vld   = 1'b0;
      pay_first = 1'b0;

      // bytes of an audio packet are counted against its length
      if (phase_ff == PH_PAD1 || phase_ff == PH_EXT1 || phase_ff == PH_CODEC ||
          phase_ff == PH_PCM || phase_ff == PH_EXT2 || phase_ff == PH_PAY) begin
         if (left_ff == 16'd0) begin
            ph  = PH_SINK;
            err = ST_TRUNC;
         end else begin
            left = left_ff - 16'd1;
            ok   = 1'b1;
         end
      end

      case (phase_ff)
         PH_HDR: begin
            if (idx_ff == 4'd3 && win != PACK_SYNC && err == ST_OK) err = ST_BAD_SYNC;
            if (idx_ff == 4'd4 && (b[7:6] != 2'b01 || !b[2]) && err == ST_OK)
               err = ST_BAD_MARK;
            if ((idx_ff == 4'd6 || idx_ff == 4'd8) && !b[2] && err == ST_OK)
               err = ST_BAD_MARK;
            if (idx_ff == 4'd9 && !b[0] && err == ST_OK) err = ST_BAD_MARK;
            if (idx_ff == 4'd12 && b[1:0] != 2'b11 && err == ST_OK) err = ST_BAD_MARK;
            if (idx_ff == 4'd13) begin
               stuff = b[2:0];
               idx   = 4'd0;
               ph    = (err != ST_OK) ? PH_SINK : PH_STUFF;
            end else begin
               idx = idx_ff + 4'd1;
            end
         end
         PH_STUFF: stuff = stuff_ff - 3'd1;
         PH_PKT: begin
            if (idx_ff == 4'd2 && win[23:0] != PKT_PREFIX && err == ST_OK)
               err = ST_BAD_START;
            if (idx_ff == 4'd5) begin
               left = win[15:0];
               idx  = 4'd0;
               if (err != ST_OK)               ph = PH_SINK;
               else if (win[23:16] == audio_id_ff) ph = PH_PAD1;
               else                            ph = PH_SKIP;
            end else begin
               idx = idx_ff + 4'd1;
            end
         end
         PH_SKIP: left = left_ff - 16'd1;
         PH_PAD1: begin
            if (ok) begin
               if (idx_ff == 4'd2) begin
                  ext = b;
                  ph  = PH_EXT1;
                  idx = 4'd0;
               end else begin
                  idx = idx_ff + 4'd1;
               end
            end
         end
         PH_EXT1: if (ok) ext = ext_ff - 8'd1;
         PH_CODEC: begin
            if (ok) begin
               if (idx_ff == 4'd0) cap[55:48] = b;
               if (idx_ff == 4'd1) cap[47:40] = b;
               if (idx_ff == 4'd3) begin
                  idx = 4'd0;
                  if (cap[55:48] == pcm_id_ff) begin
                     if (b < PCM_HDR_MIN) begin
                        ph  = PH_SINK;
                        err = ST_TRUNC;
                     end else begin
                        fmt = b - PCM_HDR_MIN;
                        ph  = PH_PCM;
                     end
                  end else begin
                     fmt = b;
                     ph  = PH_EXT2;
                  end
               end else begin
                  idx = idx_ff + 4'd1;
               end
            end
         end
         PH_PCM: begin
            if (ok) begin
               if (idx_ff == 4'd0) cap[39:32] = b;
               if (idx_ff == 4'd1) cap[31:24] = b;
               if (idx_ff == 4'd3) cap[23:16] = b;
               if (idx_ff == 4'd4) cap[15:8]  = b;
               if (idx_ff == 4'd6) cap[7:0]   = b;
               if (idx_ff == 4'd8) begin
                  idx = 4'd0;
                  ph  = PH_EXT2;
               end else begin
                  idx = idx_ff + 4'd1;
               end
            end
         end
         PH_EXT2: if (ok) fmt = fmt_ff - 8'd1;
         PH_PAY: begin
            if (ok) begin
               pay_vld   = 1'b1;
               pay_first = idx_ff[0];
               idx       = 4'd0;
            end
         end
         default: ph = PH_SINK;
      endcase

      // fall through phases whose count is already spent
      if (ph == PH_STUFF && stuff == 3'd0) begin ph = PH_PKT;   idx = 4'd0; end
      if (ph == PH_SKIP && left == 16'd0)  begin ph = PH_PKT;   idx = 4'd0; end
      if (ph == PH_EXT1 && ext == 8'd0)    begin ph = PH_CODEC; idx = 4'd0; end
      if (ph == PH_EXT2 && fmt == 8'd0) begin
         ph   = PH_PAY;
         idx  = 4'd1;
         seen = 1'b1;
      end
      if (ph == PH_PAY && left == 16'd0)   begin ph = PH_PKT;   idx = 4'd0; end

      if (ph == PH_SINK)                    status = err;
      else if (ph == PH_PKT && idx == 4'd0) status = seen ? ST_OK : ST_NO_AUDIO;
      else                                  status = ST_TRUNC;

      // the sector's last byte rearms the parser
      if (in_last_ff) begin
         phase_in = PH_HDR;
         idx_in   = 4'd0;
         win_in   = 24'd0;
         left_in  = 16'd0;
         ext_in   = 8'd0;
         fmt_in   = 8'd0;
         stuff_in = 3'd0;
         seen_in  = 1'b0;
         err_in   = ST_OK;
         cap_in   = '0;
      end else begin
         phase_in = ph;
         idx_in   = idx;
         win_in   = win[23:0];
         left_in  = left;
         ext_in   = ext;
         fmt_in   = fmt;
         stuff_in = stuff;
         seen_in  = seen;
         err_in   = err;
         cap_in   = cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR;
         idx_ff   <= 4'd0;
         win_ff   <= 24'd0;
         left_ff  <= 16'd0;
         ext_ff   <= 8'd0;
         fmt_ff   <= 8'd0;
         stuff_ff <= 3'd0;
         seen_ff  <= 1'b0;
         err_ff   <= ST_OK;
         cap_ff   <= '0;
      end else if (in_vld_ff) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         win_ff   <= win_in;
         left_ff  <= left_in;
         ext_ff   <= ext_in;
         fmt_ff   <= fmt_in;
         stuff_ff <= stuff_in;
         seen_ff  <= seen_in;
         err_ff   <= err_in;
         cap_ff   <= cap_in;
      end
   end

   // ---------------- result entries ----------------
   // entry = {packet_first, kind, data}
   logic [ENTRY_W-1:0] pay_entry;
   logic [ENTRY_W-1:0] stat_entry;

   assign pay_entry  = {pay_first, KIND_PAYLOAD, {(RSP_DATA_W-8){1'b0}}, b};
   assign stat_entry = {1'b0, KIND_STATUS,
                        cap[7:0], cap[11:8], cap[15:12], cap[19:16], cap[23:20],
                        cap[39:24], cap[47:40], cap[55:48], status, 8'h00};

   // ---------------- result queue ----------------
   logic [ENTRY_W-1:0] q_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               push_pay;
   logic               push_stat;
   logic               rsp_beat;
   logic [CNT_W-1:0]   push_n;
   logic [CNT_W:0]     need;

   assign push_pay  = in_vld_ff & pay_vld;
   assign push_stat = in_vld_ff & in_last_ff;
   assign rsp_beat  = rsp_tvalid & rsp_tready;
   assign push_n    = CNT_W'(push_pay) + CNT_W'(push_stat);

   assign wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_beat);
   assign cnt_in    = cnt_ff + push_n - CNT_W'(rsp_beat);

   // room for the byte in the input register and the one arriving, two beats each
   assign need       = {1'b0, cnt_ff} + (in_vld_ff ? (CNT_W+1)'(4) : (CNT_W+1)'(2));
   assign req_tready = (need <= (CNT_W+1)'(RSP_QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push_pay) begin
         q_ff[wr_ptr_ff] <= pay_entry;
         if (push_stat) q_ff[wr_ptr_ff + PTR_W'(1)] <= stat_entry;
      end else if (push_stat) begin
         q_ff[wr_ptr_ff] <= stat_entry;
      end
   end

   logic [ENTRY_W-1:0] head;

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tdata  = {{(RSP_TDATA_W-RSP_DATA_W){1'b0}}, head[RSP_DATA_W-1:0]};
   assign rsp_tuser  = {head[ENTRY_W-1], head[ENTRY_W-2]};

   // ---------------- assertions ----------------
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff |-> ({1'b0, cnt_ff} + (CNT_W+1)'(2) <= (CNT_W+1)'(RSP_QUEUE_DEPTH)))
      else $error("result queue could overflow");

   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && in_last_ff) |=> (phase_ff == PH_HDR && idx_ff == 4'd0 && err_ff == ST_OK))
      else $error("parser did not rearm after sector end");

   a_err_phase: assert property (@(posedge clock) disable iff (reset)
      (err_ff != ST_OK) |-> (phase_ff == PH_SINK || phase_ff == PH_HDR || phase_ff == PH_PKT))
      else $error("error latched outside header or sink");

   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == KIND_PAYLOAD) |-> (rsp_tdata[RSP_DATA_W-1:8] == '0))
      else $error("payload beat carries status fields");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0] == KIND_STATUS) |-> (rsp_tdata[7:0] == 8'h00 && !rsp_tuser[1]))
      else $error("status beat carries payload");

endmodule
